FILE: sv/pow2sa_pkg.sv
// Shared types and constants of the power-of-two segregated block allocator.
`timescale 1ns / 1ps
`default_nettype none
package pow2sa_pkg;

  localparam int REQ_W   = 21;
  localparam int ADDR_W  = 20;
  localparam int BKT_W   = 5;
  localparam int STAT_W  = 2;
  localparam int CFG_W   = 5;
  localparam int TAG_W   = 7;
  localparam int NB_W    = 23;
  localparam int CNT_W   = 14;

  localparam int MSLOP       = 4;
  localparam int CARVE_FLOOR = 3;
  localparam int CARVE_MID   = 9;
  localparam int CARVE_CEIL  = 12;
  localparam int PAGE_MIN    = 10;
  localparam int PAGE_MAX    = 16;
  localparam logic [CFG_W-1:0] PAGE_RESET = 5'd12;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [1:0] TAG_NONE  = 2'b00;
  localparam logic [1:0] TAG_ALLOC = 2'b01;
  localparam logic [1:0] TAG_FREE  = 2'b10;

  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NO_HEAP = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FREED   = 2'd2;
  localparam logic [STAT_W-1:0] STAT_BAD     = 2'd3;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_SEARCH,
    S_SPLIT_RD,
    S_SPLIT_HD,
    S_BRK,
    S_LINK,
    S_POP_RD,
    S_POP_WR,
    S_REL_RD,
    S_REL_TAG,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

FILE: sv/pow2sa_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module pow2sa_ram #(
  parameter int W  = 8,
  parameter int AW = 4
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: sv/pow2_segregated_block_allocator.sv
// Top level: sequencer, free-list heads and break pointer of the block allocator.
// Usage:
//   Request channel (in_valid/in_ready): opcode, request_bytes, user_address.
//   opcode 0 allocates, 1 releases. Each request gives exactly one result on
//   the result channel (out_valid/out_ready): granted_address, bucket, status.
//   Config channel (cfg_valid/cfg_ready) writes page_size_log2; write it only
//   while no request is in flight. cfg_ready is always high.
// Sequence (one request at a time; in_ready is high only when idle, from the
//   cycle after the result is loaded):
//   release: decode, tag read, tag update, result.
//   allocate from a non-empty list: decode, link read, pop, result.
//   refill by split: adds a search step per bucket searched, the head read
//   and head update, and a link step per block linked (2^(from-to) blocks).
//   refill from the break: adds a break step and a link step per block linked,
//   up to page/block size blocks (4096 at the largest page and smallest block).
//   Each linked block is written to both the tag RAM and the link RAM.
// Reset: a clearing pass writes all 2^(HEAP_LOG2-3) tag entries
//   (131072 at the default), with in_ready low; config writes are taken.
// Stall: the result waits in the output register; a new request is accepted
//   meanwhile, and its result waits until the previous one is taken.
`timescale 1ns / 1ps
`default_nettype none
module pow2_segregated_block_allocator #(
  parameter int NUM_BUCKETS  = 18,
  parameter int HEAP_LOG2    = 20,
  parameter int HEADER_BYTES = 12
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          opcode,
  input  wire logic [pow2sa_pkg::REQ_W-1:0]  request_bytes,
  input  wire logic [pow2sa_pkg::ADDR_W-1:0] user_address,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [pow2sa_pkg::ADDR_W-1:0] granted_address,
  output logic      [pow2sa_pkg::BKT_W-1:0]  bucket,
  output logic      [pow2sa_pkg::STAT_W-1:0] status,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [pow2sa_pkg::CFG_W-1:0]  page_size_log2
);
  import pow2sa_pkg::*;

  localparam int SLOT_W = HEAP_LOG2 - 3;
  localparam int LINK_W = SLOT_W + 1;
  localparam int XW     = HEAP_LOG2 + 24;
  localparam int SPLIT_TOP = (CARVE_CEIL < NUM_BUCKETS) ? CARVE_CEIL : NUM_BUCKETS - 1;
  localparam logic [BKT_W-1:0] NB_C  = BKT_W'(NUM_BUCKETS);
  localparam logic [BKT_W-1:0] TOP_C = BKT_W'(SPLIT_TOP);
  localparam logic [BKT_W-1:0] MID_C = BKT_W'(CARVE_MID);
  localparam logic [BKT_W-1:0] MIN_C = BKT_W'(CARVE_FLOOR);
  localparam logic [XW-1:0]    HEAP_X = XW'(1) << HEAP_LOG2;

  state_t state, state_next;

  logic [CFG_W-1:0]  page_cfg;
  logic              req_op;
  logic [REQ_W-1:0]  req_bytes;
  logic [ADDR_W-1:0] req_ua;
  logic [BKT_W-1:0]  cls;
  logic [BKT_W-1:0]  sb;
  logic [HEAP_LOG2:0] bp;
  logic [SLOT_W-1:0] lk_g;
  logic [SLOT_W-1:0] lk_start;
  logic [CNT_W-1:0]  lk_cnt;
  logic [SLOT_W-1:0] rel_g;
  logic [SLOT_W-1:0] clr_idx;
  logic [ADDR_W-1:0] res_addr;
  logic [BKT_W-1:0]  res_bkt;
  logic [STAT_W-1:0] res_st;
  logic              head_v [NUM_BUCKETS];
  logic [SLOT_W-1:0] head_g [NUM_BUCKETS];

  logic              tag_we, tag_re, link_we, link_re;
  logic [SLOT_W-1:0] tag_waddr, tag_raddr, link_waddr, link_raddr;
  logic [TAG_W-1:0]  tag_wdata, tag_rdata;
  logic [LINK_W-1:0] link_wdata, link_rdata;

  // Decode of the registered request
  logic [CFG_W-1:0]  pl;
  logic [NB_W-1:0]   nbytes, nb_m1;
  logic [BKT_W-1:0]  msb, dec_cls;
  logic              dec_hv;
  logic [ADDR_W-1:0] rel_p;
  logic              rel_bad;
  logic [SLOT_W-1:0] rel_gd;
  logic              dir_down, search_last;
  logic [XW-1:0]     siz, page, amt, bp_sum;
  logic              brk_fail, siz_fits;
  logic [SLOT_W-1:0] step;
  logic [BKT_W-1:0]  tcls;
  logic [1:0]        tst;
  logic              rel_ok;

  always_comb begin
    pl = page_cfg;
    if (page_cfg < CFG_W'(PAGE_MIN)) pl = CFG_W'(PAGE_MIN);
    if (page_cfg > CFG_W'(PAGE_MAX)) pl = CFG_W'(PAGE_MAX);
  end

  always_comb begin
    nbytes = (NB_W'(req_bytes) + NB_W'(HEADER_BYTES + MSLOP + 3)) & ~NB_W'(3);
    nb_m1  = nbytes - NB_W'(1);
    msb    = '0;
    for (int i = 0; i < NB_W; i++) begin
      if (nb_m1[i]) msb = BKT_W'(i);
    end
    dec_cls = msb - BKT_W'(2);
    dec_hv  = (dec_cls < NB_C) ? head_v[dec_cls] : 1'b0;
  end

  assign rel_p   = req_ua - ADDR_W'(HEADER_BYTES);
  assign rel_bad = (rel_p[2:0] != 3'd0) || ((XW'(rel_p) >> HEAP_LOG2) != '0);
  assign rel_gd  = SLOT_W'(XW'(rel_p) >> 3);

  assign dir_down    = (cls >= MID_C);
  assign search_last = dir_down ? (sb == cls + BKT_W'(1)) : (sb == TOP_C);

  assign siz      = XW'(1) << (cls + BKT_W'(3));
  assign page     = XW'(1) << pl;
  assign siz_fits = (siz <= page);
  assign amt      = siz_fits ? page : siz;
  assign bp_sum   = XW'(bp) + amt;
  assign brk_fail = (bp_sum > HEAP_X);
  assign step     = SLOT_W'(1) << cls;

  assign tcls   = tag_rdata[BKT_W-1:0];
  assign tst    = tag_rdata[TAG_W-1:TAG_W-2];
  assign rel_ok = (tst == TAG_ALLOC) && (tcls < NB_C);

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:    if (clr_idx == '1) state_next = S_IDLE;
      S_IDLE:     if (in_valid) state_next = S_DECODE;
      S_DECODE: begin
        if (req_op == OP_ALLOC) begin
          if (dec_cls >= NB_C)                        state_next = S_DONE;
          else if (dec_hv)                            state_next = S_POP_RD;
          else if (dec_cls >= MIN_C && dec_cls < TOP_C) state_next = S_SEARCH;
          else                                        state_next = S_BRK;
        end else begin
          if (req_ua == '0 || req_ua < ADDR_W'(HEADER_BYTES) || rel_bad)
            state_next = S_DONE;
          else
            state_next = S_REL_RD;
        end
      end
      S_SEARCH: begin
        if (head_v[sb])       state_next = S_SPLIT_RD;
        else if (search_last) state_next = S_BRK;
      end
      S_SPLIT_RD: state_next = S_SPLIT_HD;
      S_SPLIT_HD: state_next = S_LINK;
      S_BRK:      state_next = brk_fail ? S_DONE : S_LINK;
      S_LINK:     if (lk_cnt == CNT_W'(1)) state_next = S_POP_RD;
      S_POP_RD:   state_next = S_POP_WR;
      S_POP_WR:   state_next = S_DONE;
      S_REL_RD:   state_next = S_REL_TAG;
      S_REL_TAG:  state_next = S_DONE;
      S_DONE:     if (!out_valid || out_ready) state_next = S_IDLE;
      default:    state_next = S_CLEAR;
    endcase
  end

  // Memory port controls
  always_comb begin
    tag_we     = 1'b0;
    tag_waddr  = lk_g;
    tag_wdata  = {TAG_FREE, cls};
    tag_re     = 1'b0;
    tag_raddr  = rel_g;
    link_we    = 1'b0;
    link_waddr = lk_g;
    link_wdata = (lk_cnt == CNT_W'(1)) ? '0 : {1'b1, lk_g + step};
    link_re    = 1'b0;
    link_raddr = head_g[sb];
    case (state)
      S_CLEAR: begin
        tag_we    = 1'b1;
        tag_waddr = clr_idx;
        tag_wdata = {TAG_NONE, BKT_W'(0)};
      end
      S_SPLIT_RD: link_re = 1'b1;
      S_LINK: begin
        tag_we  = 1'b1;
        link_we = 1'b1;
      end
      S_POP_RD: begin
        link_re    = 1'b1;
        link_raddr = head_g[cls];
      end
      S_POP_WR: begin
        tag_we    = 1'b1;
        tag_waddr = rel_g;
        tag_wdata = {TAG_ALLOC, cls};
      end
      S_REL_RD: tag_re = 1'b1;
      S_REL_TAG: begin
        if (rel_ok) begin
          tag_we     = 1'b1;
          tag_waddr  = rel_g;
          tag_wdata  = {TAG_FREE, tcls};
          link_we    = 1'b1;
          link_waddr = rel_g;
          link_wdata = {head_v[tcls], head_g[tcls]};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      bp        <= '0;
      page_cfg  <= PAGE_RESET;
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_BUCKETS; i++) head_v[i] <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) page_cfg <= page_size_log2;
      // drop the taken result unless a new one loads in the same cycle
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;
      case (state)
        S_CLEAR: clr_idx <= clr_idx + SLOT_W'(1);
        S_IDLE: begin
          req_op    <= opcode;
          req_bytes <= request_bytes;
          req_ua    <= user_address;
        end
        S_DECODE: begin
          res_addr <= '0;
          if (req_op == OP_ALLOC) begin
            cls     <= dec_cls;
            res_bkt <= dec_cls;
            sb      <= (dec_cls >= MID_C) ? TOP_C : dec_cls + BKT_W'(1);
            res_st  <= (dec_cls >= NB_C) ? STAT_NO_HEAP : STAT_OK;
          end else begin
            res_bkt <= '0;
            rel_g   <= rel_gd;
            res_st  <= (req_ua != '0 && (req_ua < ADDR_W'(HEADER_BYTES) || rel_bad)) ?
                       STAT_BAD : STAT_OK;
          end
        end
        S_SEARCH: begin
          if (!head_v[sb] && !search_last) begin
            sb <= dir_down ? sb - BKT_W'(1) : sb + BKT_W'(1);
          end
        end
        S_SPLIT_RD: begin
          lk_g     <= head_g[sb];
          lk_start <= head_g[sb];
          lk_cnt   <= CNT_W'(1) << (sb - cls);
        end
        S_SPLIT_HD: begin
          head_v[sb] <= link_rdata[SLOT_W];
          head_g[sb] <= link_rdata[SLOT_W-1:0];
        end
        S_BRK: begin
          if (brk_fail) begin
            res_st <= STAT_NO_HEAP;
          end else begin
            lk_g     <= SLOT_W'(bp >> 3);
            lk_start <= SLOT_W'(bp >> 3);
            bp       <= (HEAP_LOG2+1)'(bp_sum);
            lk_cnt   <= siz_fits ? CNT_W'(1) << (pl - BKT_W'(3) - cls) : CNT_W'(1);
          end
        end
        S_LINK: begin
          lk_g   <= lk_g + step;
          lk_cnt <= lk_cnt - CNT_W'(1);
          if (lk_cnt == CNT_W'(1)) begin
            head_v[cls] <= 1'b1;
            head_g[cls] <= lk_start;
          end
        end
        S_POP_RD: rel_g <= head_g[cls];
        S_POP_WR: begin
          head_v[cls] <= link_rdata[SLOT_W];
          head_g[cls] <= link_rdata[SLOT_W-1:0];
          res_addr    <= ADDR_W'((XW'(rel_g) << 3) + XW'(HEADER_BYTES));
        end
        S_REL_TAG: begin
          if (rel_ok) begin
            head_v[tcls] <= 1'b1;
            head_g[tcls] <= rel_g;
            res_bkt      <= tcls;
          end else if (tst == TAG_FREE) begin
            res_st  <= STAT_FREED;
            res_bkt <= tcls;
          end else begin
            res_st <= STAT_BAD;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid       <= 1'b1;
            granted_address <= res_addr;
            bucket          <= res_bkt;
            status          <= res_st;
          end
        end
        default: ;
      endcase
    end
  end

  pow2sa_ram #(.W(TAG_W), .AW(SLOT_W)) u_tag (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tag_waddr),
    .wdata (tag_wdata),
    .re    (tag_re),
    .raddr (tag_raddr),
    .rdata (tag_rdata)
  );

  pow2sa_ram #(.W(LINK_W), .AW(SLOT_W)) u_link (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .re    (link_re),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

endmodule
`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench of the power-of-two segregated block allocator.
`timescale 1ns / 1ps
module tb;
  import pow2sa_pkg::*;

  localparam int NBKT     = 18;
  localparam int GRANULES = 1 << 17;
  localparam int HDR      = 12;
  localparam int SLOP     = 4;
  localparam int CUT_LO   = 3;
  localparam int CUT_MID  = 9;
  localparam int CUT_HI   = 12;
  localparam logic [17:0] LINK_ON   = 18'h20000;
  localparam logic [6:0]  MARK_USED = 7'h20;
  localparam logic [6:0]  MARK_FREE = 7'h40;
  localparam logic [6:0]  MARK_MASK = 7'h60;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [BKT_W-1:0]  bkt;
    logic [STAT_W-1:0] st;
  } grant_t;

  typedef struct {
    logic          op;
    int unsigned   req;
    int unsigned   addr;
    bit            rel_last;
    bit            known;
    grant_t        res;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic opcode = OP_ALLOC;
  logic [REQ_W-1:0] request_bytes = '0;
  logic [ADDR_W-1:0] user_address = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [ADDR_W-1:0] granted_address;
  logic [BKT_W-1:0] bucket;
  logic [STAT_W-1:0] status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_W-1:0] page_size_log2 = 5'd12;

  pow2_segregated_block_allocator dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .opcode(opcode),
    .request_bytes(request_bytes), .user_address(user_address),
    .out_valid(out_valid), .out_ready(out_ready),
    .granted_address(granted_address), .bucket(bucket), .status(status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .page_size_log2(page_size_log2)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // allocator shadow state
  logic [17:0] head_m [NBKT];
  logic [17:0] link_m [GRANULES];
  logic [6:0]  tag_m  [GRANULES];
  longint unsigned brk_m;
  logic [CFG_W-1:0] page_m;

  grant_t pending_grants[$];
  int unsigned live_addrs[$];
  int unsigned freed_addrs[$];
  int unsigned last_grant;
  int errors = 0;
  int send_idle = 0;
  int recv_stall = 0;
  int hold_ask = 0;
  bit hold_armed = 1'b0;
  int hold_cycles = 0;

  function automatic int unsigned eff_page();
    if (page_m < 10) return 10;
    if (page_m > 16) return 16;
    return page_m;
  endfunction

  function automatic void carve(int unsigned start, int unsigned cls, longint unsigned count);
    longint unsigned step;
    int unsigned g;
    step = 64'd1 << cls;
    for (longint unsigned k = 0; k < count; k++) begin
      g = 32'((start + k * step) & (GRANULES - 1));
      tag_m[g] = MARK_FREE | 7'(cls);
      if (k + 1 < count) link_m[g] = LINK_ON | 18'((start + (k + 1) * step) & (GRANULES - 1));
      else link_m[g] = '0;
    end
    head_m[cls] = LINK_ON | 18'(start & (GRANULES - 1));
  endfunction

  function automatic void refill(int unsigned cls);
    longint unsigned siz, page, amt, cnt;
    int found;
    int unsigned g;
    siz = 64'd1 << (cls + 3);
    page = 64'd1 << eff_page();
    found = -1;
    if (cls >= CUT_LO && cls < CUT_HI) begin
      if (cls >= CUT_MID) begin
        for (int b = CUT_HI; b > int'(cls); b--)
          if (found < 0 && head_m[b][17]) found = b;
      end else begin
        for (int b = int'(cls) + 1; b <= CUT_HI; b++)
          if (found < 0 && head_m[b][17]) found = b;
      end
      if (found >= 0) begin
        g = 32'(head_m[found][16:0]);
        head_m[found] = link_m[g];
        carve(g, cls, 64'd1 << (found - cls));
        return;
      end
    end
    if (siz <= page) begin
      amt = page; cnt = page / siz;
    end else begin
      amt = siz; cnt = 1;
    end
    if (brk_m + amt > (64'd1 << 20)) return;
    g = 32'((brk_m >> 3) & (GRANULES - 1));
    brk_m += amt;
    carve(g, cls, cnt);
  endfunction

  function automatic grant_t allocator_step(logic op, int unsigned req, int unsigned ua);
    grant_t r;
    longint unsigned nbytes, page, amt, sh;
    int unsigned cls, g, p, t;
    r = '0;
    if (op == OP_ALLOC) begin
      nbytes = (longint'(req) + HDR + SLOP + 3) & ~64'd3;
      page = 64'd1 << eff_page();
      cls = 0;
      if (nbytes <= (page >> 1)) begin
        sh = (nbytes - 1) >> 3;
        while (sh != 0) begin
          cls++;
          sh = sh >> 1;
        end
      end else begin
        amt = page;
        cls = eff_page() - 3;
        while (nbytes > amt) begin
          amt = amt << 1;
          cls++;
        end
      end
      r.bkt = BKT_W'(cls);
      if (cls >= NBKT) r.st = STAT_NO_HEAP;
      else begin
        if (!head_m[cls][17]) refill(cls);
        if (!head_m[cls][17]) r.st = STAT_NO_HEAP;
        else begin
          g = 32'(head_m[cls][16:0]);
          head_m[cls] = link_m[g];
          tag_m[g] = MARK_USED | 7'(cls);
          r.addr = ADDR_W'((g << 3) + HDR);
        end
      end
    end else if (ua != 0) begin
      if (ua < HDR) r.st = STAT_BAD;
      else begin
        p = ua - HDR;
        if ((p & 7) != 0) r.st = STAT_BAD;
        else begin
          g = p >> 3;
          t = 32'(tag_m[g]);
          cls = t & 31;
          if ((t & MARK_MASK) == MARK_USED && cls < NBKT) begin
            tag_m[g] = MARK_FREE | 7'(cls);
            link_m[g] = head_m[cls];
            head_m[cls] = LINK_ON | 18'(g);
            r.bkt = BKT_W'(cls);
          end else if ((t & MARK_MASK) == MARK_FREE) begin
            r.st = STAT_FREED;
            r.bkt = BKT_W'(cls);
          end else r.st = STAT_BAD;
        end
      end
    end
    return r;
  endfunction

  task automatic report(string what, grant_t got, grant_t want);
    errors++;
    $display("mismatch %s: got addr=%0d bkt=%0d st=%0d, want addr=%0d bkt=%0d st=%0d",
             what, got.addr, got.bkt, got.st, want.addr, want.bkt, want.st);
  endtask

  // result checker
  always @(posedge clk) begin
    grant_t got, want;
    if (!rst && out_valid && out_ready) begin
      got = '{granted_address, bucket, status};
      if (pending_grants.size() == 0) report("unexpected result", got, '0);
      else begin
        want = pending_grants.pop_front();
        if (got.addr != want.addr) report("granted_address", got, want);
        else if (got.bkt != want.bkt) report("bucket", got, want);
        else if (got.st != want.st) report("status", got, want);
      end
    end
  end

  // result receiver, with a counted long hold-off on request
  always @(posedge clk) begin
    if (hold_ask > 0 && !hold_armed) begin
      hold_armed <= 1'b1;
      hold_cycles <= hold_ask;
      out_ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else out_ready <= ($urandom_range(99) >= recv_stall);
  end

  // call at a rising edge; returns at the edge where the request is taken
  task automatic send_request(logic op, int unsigned req, int unsigned ua, bit known,
                              grant_t res);
    grant_t pred;
    req = req & ((1 << REQ_W) - 1);
    ua = ua & ((1 << ADDR_W) - 1);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_valid <= 1'b1;
    opcode <= op;
    request_bytes <= REQ_W'(req);
    user_address <= ADDR_W'(ua);
    do @(posedge clk); while (!in_ready);
    pred = allocator_step(op, req, ua);
    pending_grants.push_back(known ? res : pred);
    if (op == OP_ALLOC && pred.st == STAT_OK) begin
      live_addrs.push_back(32'(pred.addr));
      last_grant = 32'(pred.addr);
    end
    if (op == OP_RELEASE && pred.st == STAT_OK && ua != 0) freed_addrs.push_back(ua);
  endtask

  task automatic drain_and_set_page(logic [CFG_W-1:0] v);
    in_valid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_valid <= 1'b1;
    page_size_log2 <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    page_m = v;
  endtask

  task automatic random_request();
    int unsigned req, ua, k, pick;
    logic op;
    op = (live_addrs.size() < 4 || $urandom_range(99) < 52) ? OP_ALLOC : OP_RELEASE;
    req = 0;
    ua = 0;
    if (op == OP_ALLOC) begin
      pick = $urandom_range(99);
      if (pick < 72) req = $urandom_range(120);
      else if (pick < 94) req = $urandom_range(3000, 121);
      else if (pick < 97) req = $urandom_range(70000, 3001);
      else req = $urandom_range((1 << REQ_W) - 1);
      ua = $urandom_range((1 << ADDR_W) - 1);
    end else begin
      pick = $urandom_range(99);
      req = $urandom_range((1 << REQ_W) - 1);
      if (pick < 65 && live_addrs.size() > 0) begin
        k = $urandom_range(live_addrs.size() - 1);
        ua = live_addrs[k];
        live_addrs.delete(k);
      end else if (pick < 77 && freed_addrs.size() > 0) begin
        ua = freed_addrs[$urandom_range(freed_addrs.size() - 1)];
      end else if (pick < 85) ua = $urandom_range(HDR);
      else if (pick < 92) ua = ($urandom_range(GRANULES - 1) << 3) + HDR;
      else ua = $urandom_range((1 << ADDR_W) - 1);
    end
    send_request(op, req, ua, 1'b0, '0);
  endtask

  row_t rows[$];

  task automatic add_row(logic op, int unsigned req, int unsigned ua, bit rl, bit known,
                         grant_t res);
    row_t r;
    r = '{op, req, ua, rl, known, res};
    rows.push_back(r);
  endtask

  initial begin
    int unsigned ua;
    logic [CFG_W-1:0] pages[6];
    int idle_mode[6][2];
    for (int i = 0; i < NBKT; i++) head_m[i] = '0;
    for (int i = 0; i < GRANULES; i++) begin
      link_m[i] = '0;
      tag_m[i] = '0;
    end
    brk_m = 0;
    page_m = 5'd12;
    last_grant = 0;

    add_row(OP_ALLOC, 0, 0, 0, 1, '{20'd12, 5'd1, STAT_OK});
    add_row(OP_RELEASE, 0, 0, 0, 1, '{20'd0, 5'd0, STAT_OK});
    add_row(OP_RELEASE, 0, 5, 0, 1, '{20'd0, 5'd0, STAT_BAD});
    add_row(OP_RELEASE, 0, 12, 0, 1, '{20'd0, 5'd1, STAT_OK});
    add_row(OP_RELEASE, 0, 12, 0, 1, '{20'd0, 5'd1, STAT_FREED});
    add_row(OP_ALLOC, 1048576, 0, 0, 1, '{20'd0, 5'd18, STAT_NO_HEAP});
    add_row(OP_ALLOC, 2097151, 0, 0, 1, '{20'd0, 5'd19, STAT_NO_HEAP});
    add_row(OP_RELEASE, 0, 1048575, 0, 1, '{20'd0, 5'd0, STAT_BAD});
    add_row(OP_RELEASE, 0, 13, 0, 1, '{20'd0, 5'd0, STAT_BAD});
    add_row(OP_ALLOC, 30000, 0, 0, 0, '0);
    add_row(OP_RELEASE, 0, 0, 1, 0, '0);
    add_row(OP_ALLOC, 40, 0, 0, 0, '0);
    add_row(OP_ALLOC, 3000, 0, 0, 0, '0);
    add_row(OP_ALLOC, 1000, 0, 0, 0, '0);
    add_row(OP_RELEASE, 0, 0, 1, 0, '0);
    add_row(OP_ALLOC, 2040, 0, 0, 0, '0);
    add_row(OP_ALLOC, 500000, 0, 0, 0, '0);
    add_row(OP_RELEASE, 0, 0, 1, 0, '0);
    add_row(OP_RELEASE, 0, 0, 1, 0, '0);
    add_row(OP_ALLOC, 1, 0, 0, 0, '0);
    add_row(OP_RELEASE, 0, 40012, 0, 0, '0);
    add_row(OP_ALLOC, 100, 0, 0, 0, '0);

    pages = '{5'd10, 5'd16, 5'd31, 5'd0, 5'($urandom_range(16, 10)), 5'd12};
    idle_mode = '{'{0, 0}, '{79, 0}, '{0, 79}, '{22, 22}, '{0, 0}, '{79, 79}};

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    foreach (rows[i]) begin
      ua = rows[i].rel_last ? last_grant : rows[i].addr;
      if (rows[i].rel_last && live_addrs.size() > 0) void'(live_addrs.pop_back());
      send_request(rows[i].op, rows[i].req, ua, rows[i].known, rows[i].res);
    end

    for (int ph = 0; ph < 6; ph++) begin
      drain_and_set_page(pages[ph]);
      send_idle = idle_mode[ph][0];
      recv_stall = idle_mode[ph][1];
      if (ph == 2) hold_ask = 400;
      for (int n = 0; n < 172; n++) random_request();
    end
    in_valid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #50_000_000;
    $display("FAILED: results differ");
    $finish;
  end
endmodule
